[src/vrt_pkg.sv]
// Shared constants and types for the version revocation table.
`timescale 1ns / 1ps

package vrt_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam logic       FUNC_UPDATE  = 1'b0;
   localparam logic       FUNC_CHECK   = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_DEACT = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [15:0] min_version;
   } entry_type;

endpackage

[src/vrt_if.sv]
// Request and response channel interfaces of the version revocation table.
`timescale 1ns / 1ps

interface vrt_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [63:0] uuid_high;
   logic [63:0] uuid_low;
   logic [15:0] version;

   modport source (output valid, func, uuid_high, uuid_low, version, input ready);
   modport sink   (input valid, func, uuid_high, uuid_low, version, output ready);
endinterface

interface vrt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       found;

   modport source (output valid, status, found, input ready);
   modport sink   (input valid, status, found, output ready);
endinterface

[src/version_revocation_table.sv]
// Version revocation table: identifier store with sequential search.
`timescale 1ns / 1ps

// Holds up to ENTRIES records of a 128-bit identifier and a 16-bit minimum
// version in a single-port-write, single-port-read memory, filled in order of
// insertion. Each request (update or check) scans the filled records through
// the memory read port, one record per cycle with the comparison in the cycle
// after the read, and stops at the first match. After the scan the result is
// handed to the output register and the block returns to idle before the
// next request is taken. The block takes one request at a time and accepts
// the next one while the previous response still waits in the output
// register. No clearing pass is needed after reset: only records below the
// fill count are ever compared.
module version_revocation_table
   import vrt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   vrt_req_if.sink  req_bus,
   vrt_rsp_if.source rsp_bus
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   entry_type mem [ENTRIES];

   logic [1:0]       state_ff,     state_in;
   logic [CNT_W-1:0] count_ff,     count_in;
   logic [CNT_W-1:0] rd_idx_ff,    rd_idx_in;
   logic [IDX_W-1:0] cmp_idx_ff,   cmp_idx_in;
   logic             cmp_vld_ff,   cmp_vld_in;
   entry_type        mem_q_ff;
   logic             func_ff,      func_in;
   logic [63:0]      key_high_ff,  key_high_in;
   logic [63:0]      key_low_ff,   key_low_in;
   logic [15:0]      version_ff,   version_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic             res_found_ff,  res_found_in;
   logic             rsp_valid_ff,  rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_found_ff,  rsp_found_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic             hit;
   logic             rsp_load;

   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.status = rsp_status_ff;
   assign rsp_bus.found  = rsp_found_ff;

   assign hit = cmp_vld_ff && (mem_q_ff.key_high == key_high_ff)
                && (mem_q_ff.key_low == key_low_ff);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_vld_in    = 1'b0;
      func_in       = func_ff;
      key_high_in   = key_high_ff;
      key_low_in    = key_low_ff;
      version_in    = version_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      mem_we        = 1'b0;
      mem_waddr     = cmp_idx_ff;
      mem_wdata     = '{key_high: key_high_ff, key_low: key_low_ff,
                        min_version: version_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               func_in     = req_bus.func;
               key_high_in = req_bus.uuid_high;
               key_low_in  = req_bus.uuid_low;
               version_in  = req_bus.version;
               rd_idx_in   = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read runs one record ahead of the compare
            if (rd_idx_ff < count_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
            end
            if (hit) begin
               res_found_in  = 1'b1;
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
               if (func_ff == FUNC_UPDATE) begin
                  if (mem_q_ff.min_version < version_ff) begin
                     mem_we = 1'b1;
                  end
               end else if (version_ff <= mem_q_ff.min_version) begin
                  res_status_in = STATUS_DEACT;
               end
            end else if (rd_idx_ff == count_ff) begin
               res_found_in  = 1'b0;
               res_status_in = STATUS_OK;
               state_in      = ST_DONE;
               if (func_ff == FUNC_UPDATE) begin
                  if (count_ff == CNT_W'(ENTRIES)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[IDX_W-1:0];
                     count_in  = count_ff + CNT_W'(1);
                  end
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_found_in  = res_found_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= mem[rd_idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      func_ff       <= func_in;
      key_high_ff   <= key_high_in;
      key_low_ff    <= key_low_in;
      version_ff    <= version_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

endmodule

[tb/testbench.sv]
// Testbench for the version revocation table: directed table, random traffic, predictor.
`timescale 1ns / 1ps

module testbench;
   import vrt_pkg::*;

   localparam int          QUIET_LIMIT  = 2000;
   localparam int          RANDOM_ITEMS = 926;
   localparam int          PLAN_ROWS    = 24;
   localparam logic [63:0] ONES         = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic       func;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [15:0] ver;
      logic       pinned;
      logic [1:0] status;
      logic       found;
   } probe_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
   } verdict_type;

   // pinned rows carry the verdict typed in; the others go to the predictor
   localparam probe_type DIRECTED_PLAN [PLAN_ROWS] = '{
      '{FUNC_CHECK,  64'd0, 64'd0, 16'h0000, 1'b1, STATUS_OK,    1'b0},
      '{FUNC_CHECK,  ONES,  ONES,  16'hFFFF, 1'b1, STATUS_OK,    1'b0},
      '{FUNC_UPDATE, 64'd0, 64'd0, 16'h0000, 1'b1, STATUS_OK,    1'b0},
      '{FUNC_CHECK,  64'd0, 64'd0, 16'h0000, 1'b1, STATUS_DEACT, 1'b1},
      '{FUNC_CHECK,  64'd0, 64'd0, 16'h0001, 1'b1, STATUS_OK,    1'b1},
      '{FUNC_UPDATE, ONES,  ONES,  16'hFFFF, 1'b1, STATUS_OK,    1'b0},
      '{FUNC_CHECK,  ONES,  ONES,  16'hFFFF, 1'b1, STATUS_DEACT, 1'b1},
      '{FUNC_CHECK,  ONES,  ONES,  16'h0000, 1'b1, STATUS_DEACT, 1'b1},
      '{FUNC_UPDATE, 64'd0, 64'd0, 16'h0005, 1'b1, STATUS_OK,    1'b1},
      '{FUNC_UPDATE, 64'd0, 64'd0, 16'h0003, 1'b1, STATUS_OK,    1'b1},
      '{FUNC_CHECK,  64'd0, 64'd0, 16'h0005, 1'b1, STATUS_DEACT, 1'b1},
      '{FUNC_CHECK,  64'd0, 64'd0, 16'h0006, 1'b1, STATUS_OK,    1'b1},
      '{FUNC_UPDATE, 64'd0, 64'd0, 16'h0005, 1'b1, STATUS_OK,    1'b1},
      '{FUNC_CHECK,  64'd0, ONES,  16'h0000, 1'b1, STATUS_OK,    1'b0},
      '{FUNC_CHECK,  ONES,  64'd0, 16'h0000, 1'b1, STATUS_OK,    1'b0},
      '{FUNC_UPDATE, ONES,  64'd0, 16'h8000, 1'b0, STATUS_OK,    1'b0},
      '{FUNC_CHECK,  ONES,  64'd0, 16'h8000, 1'b0, STATUS_OK,    1'b0},
      '{FUNC_CHECK,  ONES,  64'd0, 16'h8001, 1'b0, STATUS_OK,    1'b0},
      '{FUNC_UPDATE, 64'h8000_0000_0000_0000, 64'd1, 16'h0001, 1'b0, STATUS_OK, 1'b0},
      '{FUNC_CHECK,  64'h8000_0000_0000_0000, 64'd0, 16'h0001, 1'b0, STATUS_OK, 1'b0},
      '{FUNC_UPDATE, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 16'h7FFF,
        1'b0, STATUS_OK, 1'b0},
      '{FUNC_CHECK,  64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 16'h7FFF,
        1'b0, STATUS_OK, 1'b0},
      '{FUNC_UPDATE, ONES,  ONES,  16'h0000, 1'b1, STATUS_OK,    1'b1},
      '{FUNC_CHECK,  ONES,  ONES,  16'hFFFF, 1'b1, STATUS_DEACT, 1'b1}
   };

   logic clock;
   logic reset;

   vrt_req_if req_bus ();
   vrt_rsp_if rsp_bus ();

   version_revocation_table dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predicted table contents
   logic [63:0] key_hi  [ENTRIES];
   logic [63:0] key_lo  [ENTRIES];
   logic [15:0] min_ver [ENTRIES];
   int          fill = 0;

   verdict_type pending [$];
   probe_type   offered;
   bit          calm;
   int          quiet_cycles = 0;
   int          fault_count = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int find_slot(logic [63:0] hi, logic [63:0] lo);
      for (int i = 0; i < fill; i++)
         if (key_hi[i] == hi && key_lo[i] == lo) return i;
      return -1;
   endfunction

   function automatic verdict_type apply_request(logic func, logic [63:0] hi,
                                                 logic [63:0] lo, logic [15:0] ver);
      verdict_type v;
      int          slot;
      slot     = find_slot(hi, lo);
      v.found  = (slot >= 0);
      v.status = STATUS_OK;
      if (func == FUNC_UPDATE) begin
         if (slot >= 0) begin
            if (ver > min_ver[slot]) min_ver[slot] = ver;
         end else if (fill >= ENTRIES) begin
            v.status = STATUS_FULL;
         end else begin
            key_hi[fill]  = hi;
            key_lo[fill]  = lo;
            min_ver[fill] = ver;
            fill++;
         end
      end else if (slot >= 0 && ver <= min_ver[slot]) begin
         v.status = STATUS_DEACT;
      end
      return v;
   endfunction

   function automatic void log_fault(string what);
      fault_count++;
      if (fault_count <= 10) $display("%0t: %s", $realtime, what);
   endfunction

   // mostly listed identifiers and near misses, some fresh ones
   function automatic probe_type random_request();
      probe_type    p;
      int           slot;
      int           pick;
      logic [127:0] id;
      p      = '0;
      p.func = 1'($urandom_range(1));
      pick   = $urandom_range(99);
      if (fill > 0 && pick < 70) begin
         slot = $urandom_range(fill - 1);
         id   = {key_hi[slot], key_lo[slot]};
         if (pick >= 60) id = id ^ (128'd1 << $urandom_range(127));
         case ($urandom_range(3))
            0:       p.ver = min_ver[slot];
            1:       p.ver = min_ver[slot] - 16'd1;
            2:       p.ver = min_ver[slot] + 16'd1;
            default: p.ver = 16'($urandom_range(16'hFFFF));
         endcase
      end else begin
         id = {$urandom, $urandom, $urandom, $urandom};
         if ($urandom_range(19) == 0) id[127:64] = $urandom_range(1) ? ONES : 64'd0;
         if ($urandom_range(19) == 0) id[63:0]   = $urandom_range(1) ? ONES : 64'd0;
         case ($urandom_range(9))
            0:       p.ver = 16'h0000;
            1:       p.ver = 16'hFFFF;
            default: p.ver = 16'($urandom_range(16'hFFFF));
         endcase
      end
      p.hi = id[127:64];
      p.lo = id[63:0];
      return p;
   endfunction

   task automatic send_request(input probe_type p);
      while (!calm && $urandom_range(99) < 7) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.func      <= p.func;
      req_bus.uuid_high <= p.hi;
      req_bus.uuid_low  <= p.lo;
      req_bus.version   <= p.ver;
      offered           <= p;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(99) >= 7);
   end

   always @(posedge clock) begin : scoreboard
      verdict_type predicted;
      verdict_type oldest;
      verdict_type got;
      if (!reset) begin
         quiet_cycles++;
         if (req_bus.valid && req_bus.ready) begin
            quiet_cycles = 0;
            predicted = apply_request(req_bus.func, req_bus.uuid_high, req_bus.uuid_low,
                                      req_bus.version);
            if (offered.pinned) predicted = {offered.status, offered.found};
            pending.push_back(predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            quiet_cycles = 0;
            got = {rsp_bus.status, rsp_bus.found};
            if (pending.size() == 0) begin
               log_fault($sformatf("unexpected transaction: status %0d found %0d",
                                   got.status, got.found));
            end else begin
               oldest = pending.pop_front();
               if (got.status !== oldest.status)
                  log_fault($sformatf("status mismatch: expected %0d, got %0d",
                                      oldest.status, got.status));
               if (got.found !== oldest.found)
                  log_fault($sformatf("found mismatch: expected %0d, got %0d",
                                      oldest.found, got.found));
            end
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("testbench failed");
      $finish;
   end

   initial begin : stimulus
      reset             = 1'b1;
      calm              = 1'b0;
      offered           = '0;
      req_bus.valid     = 1'b0;
      req_bus.func      = FUNC_UPDATE;
      req_bus.uuid_high = '0;
      req_bus.uuid_low  = '0;
      req_bus.version   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < PLAN_ROWS; i++) send_request(DIRECTED_PLAN[i]);
      drain_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i >= 600 && i < 750);
         if (i == 450) drain_results();
         send_request(random_request());
      end
      calm = 1'b0;

      drain_results();
      repeat (ENTRIES + 8) @(posedge clock);
      if (pending.size() != 0) log_fault("transactions still outstanding at the end");
      if (fault_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
